### design/md5_pkg.sv
package md5_pkg;

  localparam int WordW = 32;
  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0] PadMark = 8'h80;
  localparam int QueueDepth = 4;

  // queued item from front to back
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        final_word;
  } md5_item_t;

  function automatic logic [31:0] sine_k(input logic [5:0] r);
    logic [31:0] k;
    begin
      case (r)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    begin
      case ({r[5:4], r[1:0]})
        4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
        4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
        4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
        4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15;
        default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

endpackage

### design/md5_queue.sv
module md5_queue #(
  parameter int Depth = md5_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  md5_pkg::md5_item_t wr_item,
  output logic              rd_valid,
  input  logic              rd_ready,
  output md5_pkg::md5_item_t rd_item
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  md5_pkg::md5_item_t mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr_en, rd_en;

  assign wr_ready = (cnt_r != (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;
  assign rd_item = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_item;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule

### design/md5_front.sv
module md5_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_data,
  input  logic [2:0]        in_count,
  input  logic              in_last,
  output logic              q_valid,
  input  logic              q_ready,
  output md5_pkg::md5_item_t q_item
);
  // saturate byte count to four
  always_comb begin
    q_item.data_word  = in_data;
    q_item.byte_count = (in_count > 3'd4) ? 3'd4 : in_count;
    q_item.final_word = in_last;
  end
  assign q_valid  = in_valid;
  assign in_ready = q_ready;
endmodule

### design/md5_back.sv
module md5_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  md5_pkg::md5_item_t q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_word,
  output logic [1:0]        out_index,
  output logic              out_last
);
  typedef enum logic [2:0] {S_TAKE, S_PUSH, S_PAD, S_LEN, S_COMP, S_EMIT} state_t;

  state_t       state_r;
  state_t       ret_r;        // where to resume after a compression
  logic [31:0]  blk_r [16];   // block buffer, byte 4*i+j in word i bits 8*j+7:8*j
  logic [5:0]   fill_r;
  logic [63:0]  bits_r, len_r;
  logic [31:0]  chain_r [4];
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [5:0]   rnd_r;
  logic [31:0]  word_r;
  logic [2:0]   left_r;
  logic         fin_r, pad_done_r;
  logic [2:0]   lenb_r;
  logic [1:0]   emit_r;

  // round datapath
  logic [31:0] f, mw, sum, rot;
  logic [3:0]  g;
  logic [4:0]  sh;
  always_comb begin
    case (rnd_r[5:4])
      2'd0: begin f = (b_r & c_r) | (~b_r & d_r); g = rnd_r[3:0]; end
      2'd1: begin f = (b_r & d_r) | (c_r & ~d_r); g = 4'(5 * rnd_r + 1); end
      2'd2: begin f = b_r ^ c_r ^ d_r;            g = 4'(3 * rnd_r + 5); end
      default: begin f = c_r ^ (b_r | ~d_r);      g = 4'(7 * rnd_r); end
    endcase
    mw  = blk_r[g];
    sum = a_r + f + mw + md5_pkg::sine_k(rnd_r);
    sh  = md5_pkg::rot_amt(rnd_r);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  assign q_ready   = (state_r == S_TAKE);
  assign out_valid = (state_r == S_EMIT);
  assign out_word  = chain_r[emit_r];
  assign out_index = emit_r;
  assign out_last  = (emit_r == 2'd3);

  logic [7:0] pbyte;
  logic       pwr;
  always_comb begin
    pwr = 1'b0;
    pbyte = word_r[7:0];
    case (state_r)
      S_PUSH: begin pwr = (left_r != 3'd0); pbyte = word_r[7:0]; end
      S_PAD:  begin pwr = 1'b1; pbyte = pad_done_r ? 8'h00 : md5_pkg::PadMark; end
      S_LEN:  begin pwr = 1'b1; pbyte = len_r[7:0]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pwr) blk_r[fill_r[5:2]][{fill_r[1:0], 3'b000} +: 8] <= pbyte;
    if (!rst_n) begin
      state_r <= S_TAKE; ret_r <= S_TAKE;
      fill_r <= '0; bits_r <= '0;
      chain_r[0] <= md5_pkg::InitA; chain_r[1] <= md5_pkg::InitB;
      chain_r[2] <= md5_pkg::InitC; chain_r[3] <= md5_pkg::InitD;
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0;
      rnd_r <= '0; emit_r <= '0;
      pad_done_r <= 1'b0; lenb_r <= '0; left_r <= '0; fin_r <= 1'b0;
    end else begin
      case (state_r)
        S_TAKE: if (q_valid) begin
          word_r <= q_item.data_word;
          left_r <= q_item.byte_count;
          fin_r  <= q_item.final_word;
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (left_r != 3'd0) begin
            word_r <= word_r >> 8;
            left_r <= left_r - 1'b1;
            bits_r <= bits_r + 64'd8;
            fill_r <= fill_r + 1'b1;
            if (fill_r == 6'd63) begin
              state_r <= S_COMP; ret_r <= S_PUSH; rnd_r <= '0;
              a_r <= chain_r[0]; b_r <= chain_r[1]; c_r <= chain_r[2]; d_r <= chain_r[3];
            end
          end else if (fin_r) begin
            state_r <= S_PAD; pad_done_r <= 1'b0; len_r <= bits_r;
          end else begin
            state_r <= S_TAKE;
          end
        end
        S_PAD: begin
          pad_done_r <= 1'b1;
          fill_r <= fill_r + 1'b1;
          if (fill_r == 6'd63) begin
            // no room for the length, zeros continue in a second block
            state_r <= S_COMP; ret_r <= S_PAD; rnd_r <= '0;
            a_r <= chain_r[0]; b_r <= chain_r[1]; c_r <= chain_r[2]; d_r <= chain_r[3];
          end else if (fill_r == 6'd55) begin
            state_r <= S_LEN; lenb_r <= '0;
          end
        end
        S_LEN: begin
          len_r <= len_r >> 8;
          lenb_r <= lenb_r + 1'b1;
          fill_r <= fill_r + 1'b1;
          if (lenb_r == 3'd7) begin
            state_r <= S_COMP; ret_r <= S_EMIT; rnd_r <= '0;
            a_r <= chain_r[0]; b_r <= chain_r[1]; c_r <= chain_r[2]; d_r <= chain_r[3];
          end
        end
        S_COMP: begin
          a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 6'd63) begin
            chain_r[0] <= chain_r[0] + d_r;
            chain_r[1] <= (chain_r[1] + b_r) + rot;
            chain_r[2] <= chain_r[2] + b_r;
            chain_r[3] <= chain_r[3] + c_r;
            state_r <= ret_r;
            emit_r <= '0;
          end
        end
        S_EMIT: if (out_ready) begin
          emit_r <= emit_r + 1'b1;
          if (emit_r == 2'd3) begin
            state_r <= S_TAKE;
            chain_r[0] <= md5_pkg::InitA; chain_r[1] <= md5_pkg::InitB;
            chain_r[2] <= md5_pkg::InitC; chain_r[3] <= md5_pkg::InitD;
            fill_r <= '0; bits_r <= '0;
          end
        end
        default: state_r <= S_TAKE;
      endcase
    end
  end
endmodule

### design/md5_hash_engine.sv
// md5_hash_engine: streaming md5 digest over little-endian 32-bit words
// each word passes through the queue; the back end then takes it, writes its bytes into the block
// buffer and takes no new word until they are written; a completed 64-byte block is compressed
// over 64 rounds before the next byte; final word: 9 to 72 padding and length bytes, one or two
// compressions, then 4 digest items; reset: synchronous active-low rst_n restores init chain,
// clears counts
module md5_hash_engine #(
  parameter int QueueDepth = md5_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], byte_count[34:32], zero fill
  input  logic        in_tlast,   // final_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[33:32], zero fill
  output logic        out_tlast   // digest_last
);
  md5_pkg::md5_item_t fq_item, qb_item;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  logic [31:0] dw;
  logic [1:0]  wi;

  // front: normalizes words, saturating the byte count
  md5_front u_front (
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_data(in_tdata[31:0]), .in_count(in_tdata[34:32]), .in_last(in_tlast),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
  );

  // short queue decouples input from the round engine
  md5_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_item(qb_item)
  );

  // back: byte packing, padding, 64-round compression, digest output
  md5_back u_back (
    .clk, .rst_n, .q_valid(qb_valid), .q_ready(qb_ready), .q_item(qb_item),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_word(dw), .out_index(wi), .out_last(out_tlast)
  );

  assign out_tdata = {6'd0, wi, dw};
endmodule

### design/md5_checker.sv
module md5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[33:32] == 2'd3))) else $error("last mismatch");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:34] == 6'd0) else $error("pad bits");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out hold");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid) else $error("digest gap");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid) else $error("input dropped");
endmodule

bind md5_hash_engine md5_checker u_md5_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

### bench/md5_digest_checker.sv
`timescale 1ns / 100ps
module md5_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_digests
);
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_last;
  } digest_item_t;

  localparam logic [31:0] SineK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int Shift [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  logic [31:0]  chain [4];
  logic [7:0]   blk [64];
  int           fill;
  logic [63:0]  bit_len;
  digest_item_t digest_q [$];
  int           fails = 0;
  int           pend = 0;

  function automatic logic [31:0] rol(logic [31:0] v, int n);
    return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
  endfunction

  task automatic compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    for (int i = 0; i < 16; i++)
      m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin f = (b & c) | (~b & d); g = r; end
        1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
      endcase
      t = d; d = c; c = b;
      b = b + rol(a + f + m[g] + SineK[r], Shift[(r / 16) * 4 + r % 4]);
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic add_byte(logic [7:0] v);
    blk[fill] = v;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic start_message();
    chain[0] = md5_pkg::InitA; chain[1] = md5_pkg::InitB;
    chain[2] = md5_pkg::InitC; chain[3] = md5_pkg::InitD;
    fill = 0;
    bit_len = '0;
  endtask

  // absorb one word, queue the digest on the final one
  task automatic absorb_word(logic [31:0] w, logic [2:0] cnt, logic fin);
    int n;
    logic [63:0] len;
    n = (cnt > 4) ? 4 : cnt;
    for (int i = 0; i < n; i++) begin
      add_byte(w[8*i +: 8]);
      bit_len += 8;
    end
    if (fin) begin
      len = bit_len;
      add_byte(md5_pkg::PadMark);
      while (fill != 56) add_byte(8'h00);
      for (int i = 0; i < 8; i++) add_byte(len[8*i +: 8]);
      for (int i = 0; i < 4; i++)
        digest_q.push_back('{chain[i], 2'(i), i == 3});
      start_message();
    end
  endtask

  assign fail_count = fails;
  assign pending_digests = pend;

  initial start_message();

  always @(posedge clk) begin
    digest_item_t exp_item;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        absorb_word(in_tdata[31:0], in_tdata[34:32], in_tlast);
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest item %h", out_tdata[31:0]);
          fails++;
        end else begin
          exp_item = digest_q.pop_front();
          if (out_tdata[31:0] !== exp_item.digest_word) begin
            $error("digest_word exp %h got %h", exp_item.digest_word, out_tdata[31:0]);
            fails++;
          end
          if (out_tdata[33:32] !== exp_item.word_index) begin
            $error("word_index exp %0d got %0d", exp_item.word_index, out_tdata[33:32]);
            fails++;
          end
          if (out_tlast !== exp_item.digest_last) begin
            $error("digest_last exp %0d got %0d", exp_item.digest_last, out_tlast);
            fails++;
          end
        end
      end
      pend = digest_q.size();
    end
  end
endmodule

### bench/md5_hash_engine_tb.sv
`timescale 1ns / 100ps
module md5_hash_engine_tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // data_word[31:0], byte_count[34:32], zero fill
  logic        in_tlast = 1'b0; // final_word
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // digest_word[31:0], word_index[33:32], zero fill
  logic        out_tlast;       // digest_last
  int          fail_count;
  int          pending_digests;
  bit          steady_mode = 1'b0; // no idling on either side while set

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  md5_hash_engine dut (.*);

  md5_digest_checker checker_i (.*);

  // receiver stalls about 12 percent of cycles unless steady_mode is set
  always @(negedge clk)
    out_tready <= steady_mode || ($urandom_range(99) >= 12);

  // drive one item and hold it until accepted
  task automatic send_word(logic [31:0] w, logic [2:0] cnt, logic fin);
    while (!steady_mode && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, cnt, w};
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // a message of n words, random content; tail may be short
  task automatic send_message(int n);
    for (int i = 0; i < n - 1; i++)
      send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'($urandom_range(4)), 1'b1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_digests != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  initial begin
    int n;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty message, short finals, oversize counts, padding edges
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'h00636261, 3'd3, 1'b1);           // "abc"
    send_word(32'hffffffff, 3'd7, 1'b1);           // count saturates to four
    send_word(32'h12345678, 3'd5, 1'b0);
    send_word(32'h9abcdef0, 3'd2, 1'b0);           // short non-final word
    send_word(32'h0, 3'd6, 1'b1);
    for (int i = 0; i < 14; i++) send_word(32'ha5a5a5a5, 3'd4, 1'b0);
    send_word(32'h5a5a5a5a, 3'd0, 1'b1);           // 56 bytes: extra pad block
    drain();

    // random messages; first stretch without idling
    steady_mode = 1'b1;
    n = 0;
    while (n < 160) begin
      if (n > 40) steady_mode = 1'b0;
      case ($urandom_range(3))
        0: send_message($urandom_range(1, 3));
        1: send_message($urandom_range(13, 17));     // around the pad boundary
        2: send_message($urandom_range(4, 12));
        default: send_word($urandom, 3'($urandom), 1'($urandom_range(1)));
      endcase
      n += 8;
      if ($urandom_range(9) == 0) drain();
    end
    send_word(32'h0, 3'd0, 1'b1);
    drain();

    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
